@@ rtl/rts_pkg.sv @@
`default_nettype none

package rts_pkg;

    // Configuration register geometry.
    localparam int SIZE_W        = 11;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;

    // Row counter width, enough for rows 0 to MAX_HEIGHT-1.
    localparam int ROW_W = 10;

    // One tile gives 32 byte pairs: 16 alpha-red, then 16 green-blue.
    localparam int TILE_PAIRS = 32;
    localparam int PAIR_W     = 5;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [SIZE_W-1:0] SIZE_MASK    = 11'h7FC;
    localparam logic [SIZE_W-1:0] TILE_SIZE    = 11'd4;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       tile_done;
        logic       image_done;
    } pair_out_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } size_cfg_t;

    typedef struct packed {
        logic accept;
        logic issue;
    } dp_cmd_t;

    typedef struct packed {
        logic tile_hit;
        logic slot_free;
        logic last_pair;
    } dp_stat_t;

    // Clears the low two bits, maps zero to one tile and clamps to the limit.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                   input int limit);
        logic [SIZE_W-1:0] v;
        v = raw & SIZE_MASK;
        if (v == '0) begin
            v = TILE_SIZE;
        end
        if (int'(v) > limit) begin
            v = SIZE_W'(limit);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rts_regs.sv @@
`default_nettype none

module rts_regs #(
    parameter int MAX_WIDTH = rts_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rts_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [rts_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [rts_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output rts_pkg::size_cfg_t                  cfg
);
    import rts_pkg::*;

    logic [SIZE_W-1:0] width_raw_reg, width_raw_next;
    logic [SIZE_W-1:0] height_raw_reg, height_raw_next;
    logic [SIZE_W-1:0] width_eff_reg, width_eff_next;
    logic [SIZE_W-1:0] height_eff_reg, height_eff_next;
    logic              wr_en;
    reg_idx_t          reg_idx;
    logic [SIZE_W-1:0] wr_value;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign reg_idx  = reg_idx_t'(paddr[2]);
    assign wr_value = pwdata[SIZE_W-1:0];

    // The effective sizes are worked out at write time, so the datapath sees them ready.
    always_comb begin
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        width_eff_next  = width_eff_reg;
        height_eff_next = height_eff_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH: begin
                    width_raw_next = wr_value;
                    width_eff_next = eff_size(wr_value, MAX_WIDTH);
                end
                REG_HEIGHT: begin
                    height_raw_next = wr_value;
                    height_eff_next = eff_size(wr_value, MAX_HEIGHT);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= WIDTH_RESET;
            height_raw_reg <= HEIGHT_RESET;
            width_eff_reg  <= eff_size(WIDTH_RESET, MAX_WIDTH);
            height_eff_reg <= eff_size(HEIGHT_RESET, MAX_HEIGHT);
        end else begin
            width_raw_reg  <= width_raw_next;
            height_raw_reg <= height_raw_next;
            width_eff_reg  <= width_eff_next;
            height_eff_reg <= height_eff_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = CFG_DATA_W'(width_raw_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(height_raw_reg);
        endcase
    end

    assign cfg.width  = width_eff_reg;
    assign cfg.height = height_eff_reg;

endmodule

`default_nettype wire

@@ rtl/rts_ctrl.sv @@
`default_nettype none

module rts_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rts_pkg::dp_stat_t stat,
    output rts_pkg::dp_cmd_t       cmd
);
    import rts_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A pixel that completes a tile starts the read-out; the last read returns to idle.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.tile_hit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.slot_free && stat.last_pair) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.accept = 1'b0;
        cmd.issue  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_EMIT: begin
                cmd.issue = stat.slot_free;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rts_datapath.sv @@
`default_nettype none

module rts_datapath #(
    parameter int MAX_WIDTH = rts_pkg::MAX_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rts_pkg::pixel_in_t s_data,
    input  wire rts_pkg::size_cfg_t cfg,
    input  wire rts_pkg::dp_cmd_t   cmd,
    output rts_pkg::dp_stat_t       stat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rts_pkg::pair_out_t      m_data
);
    import rts_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
    localparam int DEPTH = 4 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CW-1:0]     col_eff;
    logic [ROW_W-1:0]  row_eff;
    logic [CMP_W-1:0]  col_inc;
    logic [SIZE_W-1:0] row_inc;
    logic              col_wrap, row_wrap;

    logic [CW-1:0]     base_reg;
    logic              last_tile_reg;
    logic [PAIR_W-1:0] pair_idx_reg, pair_idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [31:0]       rd_word_reg;
    logic              half_reg, tile_done_reg, image_done_reg;

    logic [31:0]       band_mem [DEPTH];
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [31:0]       pix_word;

    // Counters left beyond the image by a register write wrap to zero first.
    assign col_eff  = (CMP_W'(col_reg) >= CMP_W'(cfg.width)) ? '0 : col_reg;
    assign row_eff  = (SIZE_W'(row_reg) >= cfg.height) ? '0 : row_reg;
    assign col_inc  = CMP_W'(col_eff) + CMP_W'(1);
    assign row_inc  = SIZE_W'(row_eff) + SIZE_W'(1);
    assign col_wrap = col_inc >= CMP_W'(cfg.width);
    assign row_wrap = row_inc >= cfg.height;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept) begin
            col_next = col_wrap ? '0 : col_inc[CW-1:0];
            if (col_wrap) begin
                row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign stat.tile_hit  = (&row_eff[1:0]) && (&col_eff[1:0]);
    assign stat.slot_free = !rd_valid_reg || m_ready;
    assign stat.last_pair = pair_idx_reg == PAIR_W'(TILE_PAIRS - 1);

    assign pix_word = {s_data.alpha, s_data.blue, s_data.green, s_data.red};
    assign wr_addr  = AW'(row_eff[1:0]) * AW'(MAX_WIDTH) + AW'(col_eff);
    assign rd_addr  = AW'(pair_idx_reg[3:2]) * AW'(MAX_WIDTH)
                    + AW'(base_reg | CW'(pair_idx_reg[1:0]));

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            band_mem[wr_addr] <= pix_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_word_reg <= band_mem[rd_addr];
        end
    end

    always_comb begin
        pair_idx_next = pair_idx_reg;
        if (cmd.accept && stat.tile_hit) begin
            pair_idx_next = '0;
        end else if (cmd.issue) begin
            pair_idx_next = pair_idx_reg + PAIR_W'(1);
        end
    end

    assign rd_valid_next = cmd.issue ? 1'b1 : (m_ready ? 1'b0 : rd_valid_reg);

    // Tile geometry and the flags that ride along with each read word.
    always_ff @(posedge aclk) begin
        pair_idx_reg <= pair_idx_next;
        if (cmd.accept && stat.tile_hit) begin
            base_reg      <= col_eff & ~CW'(3);
            last_tile_reg <= col_wrap && row_wrap;
        end
        if (cmd.issue) begin
            half_reg       <= pair_idx_reg[PAIR_W-1];
            tile_done_reg  <= stat.last_pair;
            image_done_reg <= stat.last_pair && last_tile_reg;
        end
    end

    assign m_valid            = rd_valid_reg;
    assign m_data.first_byte  = half_reg ? rd_word_reg[15:8]  : rd_word_reg[31:24];
    assign m_data.second_byte = half_reg ? rd_word_reg[23:16] : rd_word_reg[7:0];
    assign m_data.tile_done   = tile_done_reg;
    assign m_data.image_done  = image_done_reg;

endmodule

`default_nettype wire

@@ rtl/rgba8_tile_swizzler_top.sv @@
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  pixel_in_t: red, green, blue, alpha
// m_        out        m_valid / m_ready  pair_out_t: first_byte, second_byte, flags
// APB       in         psel/penable       image_width at 0x0, image_height at 0x4
//
// An ordinary pixel transfer is written into the band memory. The pixel that
// completes a 4x4 tile starts the read-out of its 32 byte pairs, one byte pair a
// cycle while the output is not stalled, through the single read port of the band
// memory. Reset is synchronous and active low; it clears the counters and the
// control state, but not the band memory. A stalled output holds the read-out,
// while the input side still takes pixels once read-out is done.
module rgba8_tile_swizzler_top #(
    parameter int MAX_WIDTH = rts_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire rts_pkg::pixel_in_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output rts_pkg::pair_out_t                  m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rts_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [rts_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [rts_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import rts_pkg::*;

    size_cfg_t cfg;
    dp_cmd_t   cmd;
    dp_stat_t  stat;

    // The register block keeps the raw values for reads and the clamped sizes for use.
    rts_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller decides when a pixel transfer is taken and when a pair is read.
    rts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the counters, the four-row band memory and the output stage.
    // The memory read register doubles as the output register, so a read is issued
    // only when the output slot is empty or is being emptied in the same cycle.
    rts_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A pixel is never written while the band is being read out.
    a_no_write_during_read : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !cmd.issue)
        else $error("pixel transfer taken during tile read-out");

    // A tile-completing pixel stops further input until the tile is read out.
    a_tile_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && stat.tile_hit) |=> !s_ready)
        else $error("input still open after a tile-completing pixel");

    // After the last pair of a tile is read, the input side opens again.
    a_reopen_after_tile : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && stat.last_pair) |=> s_ready)
        else $error("input not reopened after the last pair of a tile");

    // The end of the image is always also the end of a tile.
    a_image_implies_tile : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.image_done) |-> m_data.tile_done)
        else $error("image_done without tile_done");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import rts_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 150;
    localparam int BURST_ITEMS  = 48;
    localparam int PLAN_ROWS    = 30;
    localparam int SETTLE_CYC   = 8;
    localparam int TAIL_CYC     = 40;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_READ,
        ROW_PIXEL
    } row_kind_t;

    // One row of the directed plan. The word is the pixel for a pixel row, the
    // value for a register write, and the expected read data for a register read.
    typedef struct packed {
        row_kind_t         kind;
        reg_idx_t          idx;
        logic [31:0]       word;
    } plan_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    pixel_in_t             s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    pair_out_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the block: register values, raster counters and the band memory.
    logic [SIZE_W-1:0]     width_reg  = WIDTH_RESET;
    logic [SIZE_W-1:0]     height_reg = HEIGHT_RESET;
    logic [ROW_W-1:0]      cur_col    = '0;
    logic [ROW_W-1:0]      cur_row    = '0;
    pixel_in_t             band_pix  [0:4*MAX_W-1];
    bit                    band_seen [0:4*MAX_W-1];
    pair_out_t             pair_q [$];
    pair_out_t             got_pair;

    plan_row_t             plan [PLAN_ROWS];
    bit                    gaps_on      = 1'b1;
    bit                    ready_stalls = 1'b1;
    int                    errors       = 0;
    int                    cycles       = 0;

    rgba8_tile_swizzler_top #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a transfer never completes.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("%0t: run stopped after %0d cycles", $time, cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // The result side holds off about 15 percent of the time while stalls are on.
    always @(posedge aclk) begin
        m_ready <= !ready_stalls || ($urandom_range(0, 99) >= 15);
    end

    // Every byte pair transfer is matched against the oldest predicted pair.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pair_q.size() == 0) begin
                $display("%0t: pair with none expected, actual %h", $time, m_data);
                errors++;
            end else begin
                got_pair = pair_q.pop_front();
                if (m_data.first_byte !== got_pair.first_byte) begin
                    $display("%0t: first_byte expected %02h actual %02h", $time,
                             got_pair.first_byte, m_data.first_byte);
                    errors++;
                end
                if (m_data.second_byte !== got_pair.second_byte) begin
                    $display("%0t: second_byte expected %02h actual %02h", $time,
                             got_pair.second_byte, m_data.second_byte);
                    errors++;
                end
                if (m_data.tile_done !== got_pair.tile_done) begin
                    $display("%0t: tile_done expected %b actual %b", $time,
                             got_pair.tile_done, m_data.tile_done);
                    errors++;
                end
                if (m_data.image_done !== got_pair.image_done) begin
                    $display("%0t: image_done expected %b actual %b", $time,
                             got_pair.image_done, m_data.image_done);
                    errors++;
                end
            end
        end
    end

    // Effective image dimension: low two bits dropped, zero means one tile,
    // anything past the limit saturates.
    function automatic logic [SIZE_W-1:0] dim_limit(input logic [SIZE_W-1:0] raw,
                                                    input int limit);
        logic [SIZE_W-1:0] v;
        v = {raw[SIZE_W-1:2], 2'b00};
        if (v == '0) begin
            v = SIZE_W'(4);
        end
        if (int'(v) > limit) begin
            v = SIZE_W'(limit);
        end
        return v;
    endfunction

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(input reg_idx_t idx);
        return CFG_ADDR_W'({idx, 2'b00});
    endfunction

    // Number of leading band columns written in all four band rows.
    function automatic int covered_cols();
        for (int c = 0; c < MAX_W; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (!band_seen[r*MAX_W + c]) begin
                    return c;
                end
            end
        end
        return MAX_W;
    endfunction

    // A new size is usable only if no tile it leads to reads a band entry that
    // was never written: either the raster restarts cleanly at a band's first
    // row and column, or every column of the new width is already filled.
    function automatic bit size_is_safe(input logic [SIZE_W-1:0] w_raw,
                                        input logic [SIZE_W-1:0] h_raw);
        logic [SIZE_W-1:0] we;
        logic [SIZE_W-1:0] he;
        logic [ROW_W-1:0]  c;
        logic [ROW_W-1:0]  r;
        we = dim_limit(w_raw, MAX_W);
        he = dim_limit(h_raw, MAX_HEIGHT);
        c  = ({1'b0, cur_col} >= we) ? '0 : cur_col;
        r  = ({1'b0, cur_row} >= he) ? '0 : cur_row;
        return (c == '0 && r[1:0] == 2'b00) || (int'(we) <= covered_cols());
    endfunction

    // Pixels still to come before the current image is complete.
    function automatic int pixels_left();
        logic [SIZE_W-1:0] we;
        logic [SIZE_W-1:0] he;
        int                c;
        int                r;
        we = dim_limit(width_reg, MAX_W);
        he = dim_limit(height_reg, MAX_HEIGHT);
        c  = ({1'b0, cur_col} >= we) ? 0 : int'(cur_col);
        r  = ({1'b0, cur_row} >= he) ? 0 : int'(cur_row);
        return (int'(he) - r) * int'(we) - c;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return SIZE_W'($urandom_range(1, 4) * 4 + $urandom_range(0, 3));
        end else if (roll < 85) begin
            return SIZE_W'($urandom_range(0, 3));
        end else if (roll < 92) begin
            return SIZE_W'(1024);
        end
        return SIZE_W'($urandom_range(1025, 2047));
    endfunction

    function automatic logic [7:0] random_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 8'h00;
        end else if (roll == 1) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    // Stores one pixel in the shadow band and queues the 32 pairs of a tile
    // when this pixel is the bottom-right corner of one.
    task automatic tile_pairs_for(input pixel_in_t px);
        logic [SIZE_W-1:0] we;
        logic [SIZE_W-1:0] he;
        logic [SIZE_W-1:0] nxt;
        pixel_in_t         stored;
        pair_out_t         pair;
        int                slot;
        we = dim_limit(width_reg, MAX_W);
        he = dim_limit(height_reg, MAX_HEIGHT);
        if ({1'b0, cur_col} >= we) begin
            cur_col = '0;
        end
        if ({1'b0, cur_row} >= he) begin
            cur_row = '0;
        end
        slot = int'(cur_row[1:0]) * MAX_W + int'(cur_col);
        band_pix[slot]  = px;
        band_seen[slot] = 1'b1;
        if (cur_row[1:0] == 2'd3 && cur_col[1:0] == 2'd3) begin
            for (int half = 0; half < 2; half++) begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        stored = band_pix[r*MAX_W + int'(cur_col) - 3 + c];
                        pair.first_byte  = (half == 0) ? stored.alpha : stored.green;
                        pair.second_byte = (half == 0) ? stored.red : stored.blue;
                        pair.tile_done   = (half == 1 && r == 3 && c == 3);
                        pair.image_done  = pair.tile_done
                                           && ({1'b0, cur_row} == he - 1'b1)
                                           && ({1'b0, cur_col} == we - 1'b1);
                        pair_q.push_back(pair);
                    end
                end
            end
        end
        nxt = {1'b0, cur_col} + 1'b1;
        if (nxt >= we) begin
            cur_col = '0;
            nxt     = {1'b0, cur_row} + 1'b1;
            cur_row = (nxt >= he) ? '0 : nxt[ROW_W-1:0];
        end else begin
            cur_col = nxt[ROW_W-1:0];
        end
    endtask

    // Drives one pixel and holds it until the transfer happens. Valid is only
    // lowered for an idle cycle, never in the step that raises it again.
    task automatic send_pixel(input pixel_in_t px);
        while (gaps_on && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        tile_pairs_for(px);
    endtask

    // Stops the pixel stream and waits until every predicted pair has arrived,
    // then waits a settle time for pixel writes that produce no pair.
    task automatic settle();
        s_valid <= 1'b0;
        while (pair_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_WIDTH) begin
            width_reg = value[SIZE_W-1:0];
        end else begin
            height_reg = value[SIZE_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic cfg_read(input reg_idx_t idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %s read expected %h actual %h", $time,
                     idx.name(), want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int                phase;
        int                sent;
        int                n;
        int                to_end;
        int                mode;
        logic [SIZE_W-1:0] w_raw;
        logic [SIZE_W-1:0] h_raw;
        logic [31:0]       junk;

        // Directed plan: reset values, the zero and below-four sizes that fall
        // back to one tile, a full 4x4 image with extreme pixel values, then
        // saturating width and height followed by a few pixels mid-row.
        plan = '{
            '{ROW_READ,  REG_WIDTH,  32'd640},
            '{ROW_READ,  REG_HEIGHT, 32'd480},
            '{ROW_WRITE, REG_WIDTH,  32'h0000_0000},
            '{ROW_WRITE, REG_HEIGHT, 32'hFFFF_F803},
            '{ROW_READ,  REG_WIDTH,  32'h0000_0000},
            '{ROW_READ,  REG_HEIGHT, 32'h0000_0003},
            '{ROW_PIXEL, REG_WIDTH,  32'h0000_0000},
            '{ROW_PIXEL, REG_WIDTH,  32'hFFFF_FFFF},
            '{ROW_PIXEL, REG_WIDTH,  32'h1222_3242},
            '{ROW_PIXEL, REG_WIDTH,  32'h1323_3343},
            '{ROW_PIXEL, REG_WIDTH,  32'hAA55_AA55},
            '{ROW_PIXEL, REG_WIDTH,  32'h55AA_55AA},
            '{ROW_PIXEL, REG_WIDTH,  32'h1626_3646},
            '{ROW_PIXEL, REG_WIDTH,  32'h1727_3747},
            '{ROW_PIXEL, REG_WIDTH,  32'h1828_3848},
            '{ROW_PIXEL, REG_WIDTH,  32'h1929_3949},
            '{ROW_PIXEL, REG_WIDTH,  32'h1A2A_3A4A},
            '{ROW_PIXEL, REG_WIDTH,  32'h1B2B_3B4B},
            '{ROW_PIXEL, REG_WIDTH,  32'h1C2C_3C4C},
            '{ROW_PIXEL, REG_WIDTH,  32'h1D2D_3D4D},
            '{ROW_PIXEL, REG_WIDTH,  32'h1E2E_3E4E},
            '{ROW_PIXEL, REG_WIDTH,  32'h1F2F_3F4F},
            '{ROW_WRITE, REG_WIDTH,  32'h0000_07FF},
            '{ROW_WRITE, REG_HEIGHT, 32'h0000_0404},
            '{ROW_READ,  REG_WIDTH,  32'h0000_07FF},
            '{ROW_READ,  REG_HEIGHT, 32'h0000_0404},
            '{ROW_PIXEL, REG_WIDTH,  32'h8080_8080},
            '{ROW_PIXEL, REG_WIDTH,  32'h7F7F_7F7F},
            '{ROW_PIXEL, REG_WIDTH,  32'h0102_0408},
            '{ROW_PIXEL, REG_WIDTH,  32'hFEFD_FBF7}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE: begin
                    settle();
                    cfg_write(plan[i].idx, plan[i].word);
                end
                ROW_READ: begin
                    settle();
                    cfg_read(plan[i].idx, plan[i].word);
                end
                default: begin
                    send_pixel(pixel_in_t'(plan[i].word));
                end
            endcase
        end

        // Random phases: each one picks new sizes (often mid-image, so the
        // counters wrap and stale band entries get reused), then mostly runs the
        // image to its end. Phase 1 is a long burst with no idling on either
        // side, running on into the next image if needed; phase 3 also drains
        // all pending pairs halfway through.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            gaps_on      = (phase != 1);
            ready_stalls = (phase != 1);
            settle();

            mode  = $urandom_range(0, 3);
            w_raw = width_reg;
            h_raw = height_reg;
            for (int tries = 0; tries < 20; tries++) begin
                w_raw = (mode == 2) ? width_reg : pick_dim();
                h_raw = (mode == 1) ? height_reg : pick_dim();
                if (size_is_safe(w_raw, h_raw)) begin
                    break;
                end
            end
            if (!size_is_safe(w_raw, h_raw)) begin
                // A one-tile width is always safe once the first image is done.
                w_raw = SIZE_W'($urandom_range(0, 7));
                h_raw = height_reg;
                mode  = 0;
            end

            junk = $urandom_range(0, 1) ? ($urandom & 32'hFFFF_F800) : 32'h0;
            if (mode != 2) begin
                cfg_write(REG_WIDTH, junk | 32'(w_raw));
            end
            if (mode != 1) begin
                cfg_write(REG_HEIGHT, junk | 32'(h_raw));
            end
            if ($urandom_range(0, 3) == 0) begin
                cfg_read(REG_HEIGHT, 32'(height_reg));
            end

            to_end = pixels_left();
            if (phase == 1) begin
                n = BURST_ITEMS;
            end else if (to_end <= 96 && $urandom_range(0, 99) < 65) begin
                n = to_end;
            end else begin
                n = $urandom_range(1, (to_end < 48) ? to_end : 48);
            end
            if (n > RANDOM_ITEMS - sent) begin
                n = RANDOM_ITEMS - sent;
            end

            for (int i = 0; i < n; i++) begin
                if (phase == 3 && i == n / 2) begin
                    settle();
                end
                send_pixel(pixel_in_t'({random_byte(), random_byte(),
                                        random_byte(), random_byte()}));
            end
            sent += n;
            phase++;
        end

        settle();
        repeat (TAIL_CYC) @(posedge aclk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rts_pkg.sv
rtl/rts_regs.sv
rtl/rts_ctrl.sv
rtl/rts_datapath.sv
rtl/rgba8_tile_swizzler_top.sv
tb/tb_top.sv
